// ===== hw/rtl/gcd_pkg.sv =====
// Shared constants, types and the CORDIC angle table of the great-circle distance unit.
`default_nettype none
package gcd_pkg;

  localparam int CordicSteps = 30;
  localparam int SqrtSteps   = 31;

  localparam logic signed [32:0] CordicGain   = 33'sd652032874;
  localparam logic [31:0]        PiQ30        = 32'd3373259426;
  // floor(2^37 / 45)
  localparam logic [31:0]        Recip45      = 32'd3054198966;
  // ceil(2^17 / 45), exact for the small remainder term
  localparam logic [11:0]        Recip45Small = 12'd2913;
  localparam logic [6:0]         Div45        = 7'd45;

  typedef enum logic [1:0] {
    CFG_REF_LAT = 2'd0,
    CFG_REF_LON = 2'd1,
    CFG_RADIUS  = 2'd2
  } gcd_cfg_idx_t;

  typedef struct packed {
    logic dbl;      // angle factor 128/45 instead of 64/45
    logic sel_sin;  // return the sine instead of the cosine
  } gcd_sc_mode_t;

  // atan(2^-i) in binary angle units (full turn = 2^32)
  function automatic logic [31:0] gcd_atan(input int idx);
    case (idx)
      0:  gcd_atan = 32'h20000000;
      1:  gcd_atan = 32'h12E4051E;
      2:  gcd_atan = 32'h09FB385B;
      3:  gcd_atan = 32'h051111D4;
      4:  gcd_atan = 32'h028B0D43;
      5:  gcd_atan = 32'h0145D7E1;
      6:  gcd_atan = 32'h00A2F61E;
      7:  gcd_atan = 32'h00517C55;
      8:  gcd_atan = 32'h0028BE53;
      9:  gcd_atan = 32'h00145F2F;
      10: gcd_atan = 32'h000A2F98;
      11: gcd_atan = 32'h000517CC;
      12: gcd_atan = 32'h00028BE6;
      13: gcd_atan = 32'h000145F3;
      14: gcd_atan = 32'h0000A2FA;
      15: gcd_atan = 32'h0000517D;
      16: gcd_atan = 32'h000028BE;
      17: gcd_atan = 32'h0000145F;
      18: gcd_atan = 32'h00000A30;
      19: gcd_atan = 32'h00000518;
      20: gcd_atan = 32'h0000028C;
      21: gcd_atan = 32'h00000146;
      22: gcd_atan = 32'h000000A3;
      23: gcd_atan = 32'h00000051;
      24: gcd_atan = 32'h00000029;
      25: gcd_atan = 32'h00000014;
      26: gcd_atan = 32'h0000000A;
      27: gcd_atan = 32'h00000005;
      28: gcd_atan = 32'h00000003;
      29: gcd_atan = 32'h00000001;
      default: gcd_atan = 32'h00000000;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/great_circle_distance_unit.sv =====
// Great-circle distance unit: haversine distance of each point from a reference point.
//
// Input channel: in_valid / in_stall with in_point_latitude and in_point_longitude
// (degrees * 2^22). Result channel: out_valid / out_stall with out_distance
// (2^-10 km). One result beat per input beat, in order.
// Configuration: cfg_valid / cfg_ready (always ready) with cfg_index and cfg_data;
// index 0 reference latitude, 1 reference longitude, 2 sphere radius, others dropped.
// Write configuration only while no item is in flight.
// Stages in order: input register, degree conversion and rotation CORDIC, the
// haversine products, the square roots, the vectoring CORDIC and clamp, and
// scaling to radians and distance.
// Throughput is one beat per cycle unless the receiver stalls; the pipeline moves as one.
// When the receiver stalls with a result waiting, every stage holds and in_stall
// rises; bubbles still move up while the output register is empty.
// Reset (rst_n low, synchronous) empties the pipeline, sets the reference point
// to 0/0 and the radius to 6371 km.
`default_nettype none
module great_circle_distance_unit import gcd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [29:0] in_point_latitude,
  input  wire logic signed [30:0] in_point_longitude,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [24:0]             out_distance,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);

  function automatic logic signed [32:0] rs30(input logic signed [63:0] v);
    logic signed [63:0] mag;
    logic signed [63:0] q;
    mag = v[63] ? -v : v;
    q   = (mag + 64'sd536870912) >>> 30;
    return v[63] ? 33'(-q) : 33'(q);
  endfunction

  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // configuration
  logic signed [29:0] ref_lat_r;
  logic signed [30:0] ref_lon_r;
  logic [22:0]        radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= '0;
      ref_lon_r <= '0;
      radius_r  <= 23'd6523904;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REF_LAT: ref_lat_r <= cfg_data[29:0];
        CFG_REF_LON: ref_lon_r <= cfg_data;
        CFG_RADIUS:  radius_r  <= cfg_data[22:0];
        default:     ;
      endcase
    end
  end

  // input register: angles and differences
  logic               t0_v_r;
  logic signed [32:0] lat1_r, lat2_r, dlat_r, dlon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_v_r <= 1'b0;
    end else if (en) begin
      t0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat1_r <= {{3{ref_lat_r[29]}}, ref_lat_r};
      lat2_r <= {{3{in_point_latitude[29]}}, in_point_latitude};
      dlat_r <= {{3{in_point_latitude[29]}}, in_point_latitude}
              - {{3{ref_lat_r[29]}}, ref_lat_r};
      dlon_r <= {{2{in_point_longitude[30]}}, in_point_longitude}
              - {{2{ref_lon_r[30]}}, ref_lon_r};
    end
  end

  logic               sc_v;
  logic signed [31:0] c1, c2, s1, s2;

  gcd_sincos u_cos1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t0_v_r), .in_value(lat1_r),
    .mode('{dbl: 1'b1, sel_sin: 1'b0}), .out_valid(), .out_value(c1)
  );
  gcd_sincos u_cos2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t0_v_r), .in_value(lat2_r),
    .mode('{dbl: 1'b1, sel_sin: 1'b0}), .out_valid(), .out_value(c2)
  );
  gcd_sincos u_sin_lat (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t0_v_r), .in_value(dlat_r),
    .mode('{dbl: 1'b0, sel_sin: 1'b1}), .out_valid(), .out_value(s1)
  );
  gcd_sincos u_sin_lon (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t0_v_r), .in_value(dlon_r),
    .mode('{dbl: 1'b0, sel_sin: 1'b1}), .out_valid(sc_v), .out_value(s2)
  );

  // haversine term
  logic               p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  logic signed [63:0] ph1_r, ph2_r, pcc_r, pm_r;
  logic signed [32:0] h1_r, h2_r, cc_r, h1d_r;
  logic [30:0]        a_r;
  logic signed [33:0] a_sum;

  assign a_sum = 34'(h1d_r) + 34'(rs30(pm_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= sc_v;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph1_r <= s1 * s1;
      ph2_r <= s2 * s2;
      pcc_r <= c1 * c2;
      h1_r  <= rs30(ph1_r);
      h2_r  <= rs30(ph2_r);
      cc_r  <= rs30(pcc_r);
      pm_r  <= 64'(cc_r * h2_r);
      h1d_r <= h1_r;
      // clamp a to [0, 1]
      if (a_sum[33]) begin
        a_r <= '0;
      end else if (a_sum > 34'sd1073741824) begin
        a_r <= 31'd1073741824;
      end else begin
        a_r <= a_sum[30:0];
      end
    end
  end

  logic        sq_v;
  logic [30:0] sqa, sqb;

  gcd_isqrt u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(p4_v_r), .in_value(a_r),
    .out_valid(sq_v), .out_root(sqa)
  );
  gcd_isqrt u_sqrt_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(p4_v_r),
    .in_value(31'd1073741824 - a_r), .out_valid(), .out_root(sqb)
  );

  // vectoring CORDIC for atan2(sqrt a, sqrt(1-a))
  logic               vv_r [0:CordicSteps];
  logic signed [32:0] vx_r [0:CordicSteps];
  logic signed [32:0] vy_r [0:CordicSteps];
  logic signed [31:0] vz_r [0:CordicSteps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_r[0] <= 1'b0;
    end else if (en) begin
      vv_r[0] <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= {2'b00, sqb};
      vy_r[0] <= {2'b00, sqa};
      vz_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < CordicSteps; k++) begin : g_vec
    logic signed [32:0] dx, dy;
    logic               ypos;
    assign dx   = vy_r[k] >>> k;
    assign dy   = vx_r[k] >>> k;
    assign ypos = !vy_r[k][32] && (vy_r[k] != 33'sd0);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vv_r[k+1] <= 1'b0;
      end else if (en) begin
        vv_r[k+1] <= vv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (ypos) begin
          vx_r[k+1] <= vx_r[k] + dx;
          vy_r[k+1] <= vy_r[k] - dy;
          vz_r[k+1] <= vz_r[k] + $signed(gcd_atan(k));
        end else begin
          vx_r[k+1] <= vx_r[k] - dx;
          vy_r[k+1] <= vy_r[k] + dy;
          vz_r[k+1] <= vz_r[k] - $signed(gcd_atan(k));
        end
      end
    end
  end

  // clamp angle, scale to radians, then to distance
  logic               ang_v_r, m1_v_r, m2_v_r, m3_v_r;
  logic [30:0]        ang_r;
  logic [62:0]        mp_r;
  logic [31:0]        crad_r;
  logic [54:0]        dp_r;
  logic [24:0]        dist_r;
  logic signed [31:0] zf;
  logic [62:0]        mp_sum;
  logic [55:0]        dp_sum;

  assign zf     = vz_r[CordicSteps];
  assign mp_sum = mp_r + 63'd536870912;
  assign dp_sum = {1'b0, dp_r} + 56'd536870912;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_v_r     <= 1'b0;
      m1_v_r      <= 1'b0;
      m2_v_r      <= 1'b0;
      m3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ang_v_r     <= vv_r[CordicSteps];
      m1_v_r      <= ang_v_r;
      m2_v_r      <= m1_v_r;
      m3_v_r      <= m2_v_r;
      out_valid_r <= m3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zf[31]) begin
        ang_r <= '0;
      end else if (zf > 32'sd1073741824) begin
        ang_r <= 31'd1073741824;
      end else begin
        ang_r <= zf[30:0];
      end
      mp_r   <= ang_r * PiQ30;
      crad_r <= mp_sum[61:30];
      dp_r   <= crad_r * radius_r;
      dist_r <= dp_sum[54:30];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = dist_r;

endmodule
`default_nettype wire

// ===== hw/rtl/gcd_sincos.sv =====
// Pipelined degree-to-angle conversion followed by a rotation CORDIC (sine or cosine).
`default_nettype none
module gcd_sincos import gcd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [32:0] in_value,
  input  wire gcd_sc_mode_t       mode,
  output logic                    out_valid,
  output logic signed [31:0]      out_value
);

  // stage 0: magnitude and sign
  logic        v0_r, s0_r;
  logic [31:0] m0_r;
  logic [32:0] mag;
  assign mag = in_value[32] ? 33'(-in_value) : in_value;

  // stage 1: reciprocal multiply for the divide by 45
  logic        v1_r, s1_r;
  logic [31:0] m1_r;
  logic [63:0] p1_r;

  // stage 2: quotient correction
  logic        v2_r, s2_r;
  logic [26:0] q2_r;
  logic [5:0]  r2_r;
  logic [26:0] q0;
  logic [13:0] q45;
  logic [6:0]  r0;
  logic        ge;
  assign q0  = p1_r[63:37];
  assign q45 = q0[6:0] * Div45;
  assign r0  = m1_r[6:0] - q45[6:0];
  assign ge  = (r0 >= Div45);

  // stage 3: rounded binary angle
  logic        v3_r;
  logic [31:0] t3_r;
  logic [11:0] tsm;
  logic [23:0] fsm;
  logic [31:0] qa;
  assign tsm = {r2_r, 6'b0} + 12'd22;
  assign fsm = tsm * Recip45Small;
  assign qa  = {q2_r[25:0], fsm[22:17]};

  // stage 4 onward: CORDIC
  logic               cv_r [0:CordicSteps];
  logic               cn_r [0:CordicSteps];
  logic signed [32:0] cx_r [0:CordicSteps];
  logic signed [32:0] cy_r [0:CordicSteps];
  logic signed [31:0] cz_r [0:CordicSteps];
  logic               flip;
  assign flip = (t3_r[31:30] == 2'b01) || (t3_r[31:30] == 2'b10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      cv_r[0] <= 1'b0;
    end else if (en) begin
      v0_r  <= in_valid;
      v1_r  <= v0_r;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      cv_r[0] <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= in_value[32];
      m0_r <= mode.dbl ? {mag[30:0], 1'b0} : mag[31:0];
      s1_r <= s0_r;
      m1_r <= m0_r;
      p1_r <= m0_r * Recip45;
      s2_r <= s1_r;
      q2_r <= q0 + 27'(ge);
      r2_r <= ge ? 6'(r0 - Div45) : r0[5:0];
      t3_r <= s2_r ? 32'(-qa) : qa;
      // fold the left half-plane by half a turn, negate at the end
      cn_r[0] <= flip;
      cz_r[0] <= $signed(flip ? (t3_r ^ 32'h80000000) : t3_r);
      cx_r[0] <= CordicGain;
      cy_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < CordicSteps; k++) begin : g_rot
    logic signed [32:0] dx, dy;
    assign dx = cy_r[k] >>> k;
    assign dy = cx_r[k] >>> k;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k+1] <= 1'b0;
      end else if (en) begin
        cv_r[k+1] <= cv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cn_r[k+1] <= cn_r[k];
        if (!cz_r[k][31]) begin
          cx_r[k+1] <= cx_r[k] - dx;
          cy_r[k+1] <= cy_r[k] + dy;
          cz_r[k+1] <= cz_r[k] - $signed(gcd_atan(k));
        end else begin
          cx_r[k+1] <= cx_r[k] + dx;
          cy_r[k+1] <= cy_r[k] - dy;
          cz_r[k+1] <= cz_r[k] + $signed(gcd_atan(k));
        end
      end
    end
  end

  logic               ov_r;
  logic signed [31:0] ovl_r;
  logic signed [32:0] sel;
  assign sel = mode.sel_sin ? cy_r[CordicSteps] : cx_r[CordicSteps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= cv_r[CordicSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovl_r <= cn_r[CordicSteps] ? 32'(-sel) : 32'(sel);
    end
  end

  assign out_valid = ov_r;
  assign out_value = ovl_r;

endmodule
`default_nettype wire

// ===== hw/rtl/gcd_isqrt.sv =====
// Pipelined floor square root of a Q30 value, one result bit per stage.
`default_nettype none
module gcd_isqrt import gcd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [30:0] in_value,
  output logic             out_valid,
  output logic [30:0]      out_root
);

  logic        sv_r   [0:SqrtSteps];
  logic [33:0] rem_r  [0:SqrtSteps];
  logic [30:0] root_r [0:SqrtSteps];
  logic [61:0] rad_r  [0:SqrtSteps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      rad_r[0]  <= {1'b0, in_value, 30'b0};
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    logic [35:0] rn, trial;
    assign rn    = {rem_r[k], rad_r[k][61:60]};
    assign trial = {3'b0, root_r[k], 2'b01};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (en) begin
        sv_r[k+1] <= sv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1] <= {rad_r[k][59:0], 2'b00};
        if (rn >= trial) begin
          rem_r[k+1]  <= 34'(rn - trial);
          root_r[k+1] <= {root_r[k][29:0], 1'b1};
        end else begin
          rem_r[k+1]  <= rn[33:0];
          root_r[k+1] <= {root_r[k][29:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = sv_r[SqrtSteps];
  assign out_root  = root_r[SqrtSteps];

endmodule
`default_nettype wire
